// ===== src/i2cms_pkg.sv =====
// shared types and constants for the i2c master bit sequencer
// used by the front, queue, back and top level modules
`default_nettype none

package i2cms_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BYTE_W        = BITS_PER_BYTE;
   localparam int TICKS_W       = 16;
   localparam int PHASE_W       = 5;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(1);

   typedef enum logic [2:0] {
      FUNC_START = 3'd0,
      FUNC_STOP  = 3'd1,
      FUNC_WRITE = 3'd2,
      FUNC_READ  = 3'd3,
      FUNC_SACK  = 3'd4,
      FUNC_RACK  = 3'd5
   } func_type;

   // one classified tick as it travels from front to back
   typedef struct packed {
      logic              launch_ok;
      func_type          func;
      logic [BYTE_W-1:0] shift_init;
      logic              sda_in;
   } item_type;

   // number of line phases in each command
   function automatic logic [PHASE_W-1:0] seq_len(input func_type cmd);
      logic [PHASE_W-1:0] len;
      unique case (cmd)
         FUNC_START: len = PHASE_W'(4);
         FUNC_STOP:  len = PHASE_W'(3);
         FUNC_WRITE: len = PHASE_W'(3 * BITS_PER_BYTE);
         FUNC_READ:  len = PHASE_W'(1 + 2 * BITS_PER_BYTE);
         default:    len = PHASE_W'(3);
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== src/i2cms_front.sv =====
// front end: takes tick words from the request channel and classifies them
// depends on i2cms_pkg
`default_nettype none

module i2cms_front (
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_cmd_valid,
   input  wire logic [2:0]                  req_func,
   input  wire logic [i2cms_pkg::BYTE_W-1:0] req_tx_byte,
   input  wire logic                        req_ack_bit,
   input  wire logic                        req_sda_in,
   input  wire logic                        queue_full,
   output logic                             push,
   output i2cms_pkg::item_type              push_item
);
   import i2cms_pkg::*;

   func_type func;

   always_comb begin
      func      = func_type'(req_func);
      req_stall = queue_full;
      push      = req_valid && !queue_full;

      // codes past receive ack never launch a command
      push_item.launch_ok = req_cmd_valid && (req_func <= 3'(FUNC_RACK));
      push_item.func      = func;
      push_item.sda_in    = req_sda_in;
      if (req_func == 3'(FUNC_WRITE)) begin
         push_item.shift_init = req_tx_byte;
      end else if (req_func == 3'(FUNC_SACK)) begin
         push_item.shift_init = {{(BYTE_W-1){1'b0}}, req_ack_bit};
      end else begin
         push_item.shift_init = '0;
      end
   end

endmodule

`default_nettype wire

// ===== src/i2cms_queue.sv =====
// short fifo of classified tick words between front and back
// depends on i2cms_pkg
`default_nettype none

module i2cms_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire i2cms_pkg::item_type push_item,
   output logic                     full,
   output logic                     head_valid,
   output i2cms_pkg::item_type      head_item,
   input  wire logic                pop
);
   import i2cms_pkg::*;

   item_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]  count_ff, count_in;

   always_comb begin
      full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_item  = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in  = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/i2cms_back.sv =====
// back end: line sequencer state, phase timing and the registered response
// depends on i2cms_pkg
`default_nettype none

module i2cms_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [i2cms_pkg::TICKS_W-1:0] csr_phase_ticks,
   input  wire logic                         head_valid,
   input  wire i2cms_pkg::item_type          head_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_scl_level,
   output logic                              rsp_sda_level,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic [i2cms_pkg::BYTE_W-1:0]      rsp_rx_byte,
   output logic                              rsp_rx_ack,
   output logic                              rsp_nack_seen
);
   import i2cms_pkg::*;

   logic [TICKS_W-1:0] ticks_ff;
   func_type           cmd_ff, cmd_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [TICKS_W-1:0] hold_ff, hold_in;
   logic [1:0]         sub_ff, sub_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic               busy_ff, busy_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               rack_ff, rack_in;
   logic               nack_ff, nack_in;
   logic [BYTE_W-1:0]  rx_ff, rx_in;
   logic               out_valid_ff, out_valid_in;
   logic               done;

   logic               launch;
   func_type           cmd;
   logic [PHASE_W-1:0] phase;
   logic [PHASE_W-1:0] phase_inc;
   logic [TICKS_W-1:0] hold;
   logic [TICKS_W:0]   hold_inc;
   logic [TICKS_W:0]   limit;
   logic [1:0]         sub;
   logic [BYTE_W-1:0]  shift;
   logic               phase_end;

   assign csr_ready = 1'b1;

   always_comb begin
      pop          = head_valid && (!out_valid_ff || !rsp_stall);
      out_valid_in = pop || (out_valid_ff && rsp_stall);

      launch    = !busy_ff && head_item.launch_ok;
      cmd       = launch ? head_item.func : cmd_ff;
      phase     = launch ? '0 : phase_ff;
      hold      = launch ? '0 : hold_ff;
      sub       = launch ? '0 : sub_ff;
      shift     = launch ? head_item.shift_init : shift_ff;
      phase_inc = phase + PHASE_W'(1);
      hold_inc  = {1'b0, hold} + (TICKS_W+1)'(1);
      limit     = {1'b0, (ticks_ff == '0) ? TICKS_W'(1) : ticks_ff};
      phase_end = (hold_inc >= limit);

      cmd_in   = cmd;
      phase_in = phase;
      hold_in  = hold;
      sub_in   = sub;
      shift_in = shift;
      busy_in  = busy_ff || launch;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      rack_in  = rack_ff;
      nack_in  = nack_ff;
      rx_in    = rx_ff;
      done     = 1'b0;

      if (!pop) begin
         cmd_in   = cmd_ff;
         phase_in = phase_ff;
         hold_in  = hold_ff;
         sub_in   = sub_ff;
         shift_in = shift_ff;
         busy_in  = busy_ff;
      end else if (busy_ff || launch) begin
         // line write happens on the first tick of each phase
         if (hold == '0) begin
            unique case (cmd)
               FUNC_START: begin
                  if (phase == PHASE_W'(0)) sda_in = 1'b1;
                  else if (phase == PHASE_W'(1)) scl_in = 1'b1;
                  else if (phase == PHASE_W'(2)) sda_in = 1'b0;
                  else scl_in = 1'b0;
               end
               FUNC_STOP: begin
                  if (phase == PHASE_W'(0)) sda_in = 1'b0;
                  else if (phase == PHASE_W'(1)) scl_in = 1'b1;
                  else sda_in = 1'b1;
               end
               FUNC_WRITE: begin
                  if (sub == 2'd0) sda_in = shift[BYTE_W-1];
                  else scl_in = (sub == 2'd1);
               end
               FUNC_READ: begin
                  if (phase == PHASE_W'(0)) sda_in = 1'b1;
                  else scl_in = phase[0];
               end
               FUNC_SACK: begin
                  if (phase == PHASE_W'(0)) sda_in = shift[0];
                  else scl_in = (phase == PHASE_W'(1));
               end
               default: begin
                  if (phase == PHASE_W'(0)) sda_in = 1'b1;
                  else scl_in = (phase == PHASE_W'(1));
               end
            endcase
         end

         hold_in = hold_inc[TICKS_W-1:0];
         if (phase_end) begin
            // sample at the end of the scl high phase
            if (cmd == FUNC_READ && phase[0]) begin
               shift_in = {shift[BYTE_W-2:0], head_item.sda_in};
            end else if (cmd == FUNC_RACK && phase == PHASE_W'(1)) begin
               rack_in = head_item.sda_in;
               nack_in = nack_ff || head_item.sda_in;
            end
            // write byte: three phases per bit, next bit after scl low
            if (cmd == FUNC_WRITE) begin
               if (sub == 2'd2) begin
                  sub_in   = 2'd0;
                  shift_in = {shift[BYTE_W-2:0], 1'b0};
               end else begin
                  sub_in = sub + 2'd1;
               end
            end
            hold_in  = '0;
            phase_in = phase_inc;
            if (phase_inc >= seq_len(cmd)) begin
               if (cmd == FUNC_READ) rx_in = shift_in;
               busy_in  = 1'b0;
               phase_in = '0;
               done     = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= TICKS_RESET;
         cmd_ff       <= FUNC_START;
         phase_ff     <= '0;
         hold_ff      <= '0;
         sub_ff       <= '0;
         shift_ff     <= '0;
         busy_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rack_ff      <= 1'b0;
         nack_ff      <= 1'b0;
         rx_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ticks_ff <= csr_phase_ticks;
         end
         cmd_ff       <= cmd_in;
         phase_ff     <= phase_in;
         hold_ff      <= hold_in;
         sub_ff       <= sub_in;
         shift_ff     <= shift_in;
         busy_ff      <= busy_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rack_ff      <= rack_in;
         nack_ff      <= nack_in;
         rx_ff        <= rx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_scl_level <= scl_in;
         rsp_sda_level <= sda_in;
         rsp_busy_res  <= busy_in;
         rsp_done_res  <= done;
         rsp_rx_byte   <= rx_in;
         rsp_rx_ack    <= rack_in;
         rsp_nack_seen <= nack_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

// ===== src/i2c_master_bit_sequencer.sv =====
// i2c master bit sequencer: one tick word in, one line-state word out
// a word accepted is held in the queue, then written to the response register when popped
// throughput: one word per cycle unless the queue fills or the response stalls; the sequencer step is combinational
// a 4-deep queue between front and back absorbs response stalls
// reset: synchronous; lines released, idle, phase_ticks back to 1
// top level, depends on i2cms_pkg, i2cms_front, i2cms_queue, i2cms_back
`default_nettype none

module i2c_master_bit_sequencer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cmd_valid,
   input  wire logic [2:0]                    req_func,
   input  wire logic [i2cms_pkg::BYTE_W-1:0]  req_tx_byte,
   input  wire logic                          req_ack_bit,
   input  wire logic                          req_sda_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_scl_level,
   output logic                               rsp_sda_level,
   output logic                               rsp_busy_res,
   output logic                               rsp_done_res,
   output logic [i2cms_pkg::BYTE_W-1:0]       rsp_rx_byte,
   output logic                               rsp_rx_ack,
   output logic                               rsp_nack_seen,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [i2cms_pkg::TICKS_W-1:0] csr_phase_ticks
);
   import i2cms_pkg::*;

   logic     queue_full;
   logic     push;
   item_type push_item;
   logic     head_valid;
   item_type head_item;
   logic     pop;

   i2cms_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd_valid (req_cmd_valid),
      .req_func      (req_func),
      .req_tx_byte   (req_tx_byte),
      .req_ack_bit   (req_ack_bit),
      .req_sda_in    (req_sda_in),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   i2cms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   i2cms_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_phase_ticks (csr_phase_ticks),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_rx_ack      (rsp_rx_ack),
      .rsp_nack_seen   (rsp_nack_seen)
   );

endmodule

`default_nettype wire

// ===== test/i2cms_line_checker.sv =====
`timescale 1ns / 100ps
// line-state checker for the i2c master bit sequencer testbench
// models the sequencer from accepted tick words and csr writes, compares response words
// depends on i2cms_pkg for the function codes and widths

module i2cms_line_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic                          req_cmd_valid,
   input  wire logic [2:0]                    req_func,
   input  wire logic [i2cms_pkg::BYTE_W-1:0]  req_tx_byte,
   input  wire logic                          req_ack_bit,
   input  wire logic                          req_sda_in,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic                          rsp_scl_level,
   input  wire logic                          rsp_sda_level,
   input  wire logic                          rsp_busy_res,
   input  wire logic                          rsp_done_res,
   input  wire logic [i2cms_pkg::BYTE_W-1:0]  rsp_rx_byte,
   input  wire logic                          rsp_rx_ack,
   input  wire logic                          rsp_nack_seen,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [i2cms_pkg::TICKS_W-1:0] csr_phase_ticks,
   output int                                 pending_count,
   output int                                 fail_count
);

   import i2cms_pkg::*;

   typedef struct packed {
      logic              scl;
      logic              sda;
      logic              busy;
      logic              done;
      logic [BYTE_W-1:0] rx_byte;
      logic              rx_ack;
      logic              nack;
   } line_word_type;

   line_word_type      line_words_due[$];
   int                 errors = 0;

   // sequencer copy
   logic [TICKS_W-1:0] tick_limit;
   func_type           seq_cmd;
   logic [PHASE_W-1:0] seq_phase;
   logic [TICKS_W-1:0] seq_hold;
   logic [BYTE_W-1:0]  seq_shift;
   logic               seq_busy;
   logic               line_scl;
   logic               line_sda;
   logic               ack_last;
   logic               nack_sticky;
   logic [BYTE_W-1:0]  rx_last;

   function automatic int phases_of(input func_type cmd);
      case (cmd)
         FUNC_START: return 4;
         FUNC_STOP:  return 3;
         FUNC_WRITE: return 3 * BITS_PER_BYTE;
         FUNC_READ:  return 1 + 2 * BITS_PER_BYTE;
         default:    return 3;
      endcase
   endfunction

   task automatic clear_sequencer();
      tick_limit  = TICKS_RESET;
      seq_cmd     = FUNC_START;
      seq_phase   = '0;
      seq_hold    = '0;
      seq_shift   = '0;
      seq_busy    = 1'b0;
      line_scl    = 1'b1;
      line_sda    = 1'b1;
      ack_last    = 1'b0;
      nack_sticky = 1'b0;
      rx_last     = '0;
   endtask

   // line write made on the first tick of a phase
   task automatic drive_phase();
      int idx;
      int bitno;
      idx = int'(seq_phase);
      case (seq_cmd)
         FUNC_START: begin
            if (idx == 0) line_sda = 1'b1;
            else if (idx == 1) line_scl = 1'b1;
            else if (idx == 2) line_sda = 1'b0;
            else line_scl = 1'b0;
         end
         FUNC_STOP: begin
            if (idx == 0) line_sda = 1'b0;
            else if (idx == 1) line_scl = 1'b1;
            else line_sda = 1'b1;
         end
         FUNC_WRITE: begin
            bitno = (idx / 3) % BITS_PER_BYTE;
            if (idx % 3 == 0) line_sda = seq_shift[BITS_PER_BYTE - 1 - bitno];
            else line_scl = (idx % 3 == 1);
         end
         FUNC_READ: begin
            if (idx == 0) line_sda = 1'b1;
            else line_scl = ((idx - 1) % 2 == 0);
         end
         FUNC_SACK: begin
            if (idx == 0) line_sda = seq_shift[0];
            else line_scl = (idx == 1);
         end
         default: begin
            if (idx == 0) line_sda = 1'b1;
            else line_scl = (idx == 1);
         end
      endcase
   endtask

   // sda is taken on the last tick of an scl-high phase
   task automatic sample_sda(input logic sd);
      int idx;
      int bitno;
      idx = int'(seq_phase);
      if (seq_cmd == FUNC_READ && idx >= 1 && (idx - 1) % 2 == 0) begin
         bitno = ((idx - 1) / 2) % BITS_PER_BYTE;
         if (sd) seq_shift[BITS_PER_BYTE - 1 - bitno] = 1'b1;
      end else if (seq_cmd == FUNC_RACK && idx == 1) begin
         ack_last = sd;
         if (sd) nack_sticky = 1'b1;
      end
   endtask

   task automatic sequencer_tick(input logic cv, input logic [2:0] fn,
                                 input logic [BYTE_W-1:0] tx, input logic ak,
                                 input logic sd, output line_word_type word);
      int  limit;
      logic done;
      limit = (tick_limit == '0) ? 1 : int'(tick_limit);
      done = 1'b0;
      if (!seq_busy && cv && int'(fn) <= int'(FUNC_RACK)) begin
         seq_cmd   = func_type'(fn);
         seq_phase = '0;
         seq_hold  = '0;
         seq_busy  = 1'b1;
         if (seq_cmd == FUNC_WRITE) seq_shift = tx;
         else if (seq_cmd == FUNC_SACK) seq_shift = {{(BYTE_W-1){1'b0}}, ak};
         else seq_shift = '0;
      end
      if (seq_busy) begin
         if (seq_hold == '0) drive_phase();
         seq_hold = seq_hold + 1'b1;
         if (int'(seq_hold) >= limit) begin
            sample_sda(sd);
            seq_hold  = '0;
            seq_phase = seq_phase + 1'b1;
            if (int'(seq_phase) >= phases_of(seq_cmd)) begin
               if (seq_cmd == FUNC_READ) rx_last = seq_shift;
               seq_busy  = 1'b0;
               seq_phase = '0;
               done      = 1'b1;
            end
         end
      end
      word.scl     = line_scl;
      word.sda     = line_sda;
      word.busy    = seq_busy;
      word.done    = done;
      word.rx_byte = rx_last;
      word.rx_ack  = ack_last;
      word.nack    = nack_sticky;
   endtask

   task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                              input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      line_word_type want;
      if (reset) begin
         clear_sequencer();
         line_words_due.delete();
      end else begin
         if (csr_valid && csr_ready) tick_limit = csr_phase_ticks;
         if (rsp_valid && !rsp_stall) begin
            if (line_words_due.size() == 0) begin
               $display("%0t: response word with none pending, expected nothing %s",
                        $time, "actual");
               $display("   %b%b%b%b %h %b%b", rsp_scl_level, rsp_sda_level,
                        rsp_busy_res, rsp_done_res, rsp_rx_byte, rsp_rx_ack,
                        rsp_nack_seen);
               errors++;
            end else begin
               want = line_words_due.pop_front();
               check_field("scl_level", BYTE_W'(want.scl), BYTE_W'(rsp_scl_level));
               check_field("sda_level", BYTE_W'(want.sda), BYTE_W'(rsp_sda_level));
               check_field("busy_res", BYTE_W'(want.busy), BYTE_W'(rsp_busy_res));
               check_field("done_res", BYTE_W'(want.done), BYTE_W'(rsp_done_res));
               check_field("rx_byte", want.rx_byte, rsp_rx_byte);
               check_field("rx_ack", BYTE_W'(want.rx_ack), BYTE_W'(rsp_rx_ack));
               check_field("nack_seen", BYTE_W'(want.nack), BYTE_W'(rsp_nack_seen));
            end
         end
         if (req_valid && !req_stall) begin
            sequencer_tick(req_cmd_valid, req_func, req_tx_byte, req_ack_bit, req_sda_in,
                           want);
            line_words_due.push_back(want);
         end
      end
      pending_count <= line_words_due.size();
      fail_count    <= errors;
   end

endmodule

// ===== test/tb_i2c_master_bit_sequencer.sv =====
`timescale 1ns / 100ps
// testbench top for the i2c master bit sequencer: clock, reset, tick words, csr writes
// depends on i2cms_pkg, i2c_master_bit_sequencer and i2cms_line_checker

module tb_i2c_master_bit_sequencer;

   import i2cms_pkg::*;

   // function codes the block must ignore
   localparam logic [2:0] FUNC_UNDEF_A = 3'd6;
   localparam logic [2:0] FUNC_UNDEF_B = 3'd7;

   localparam int LONG_HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT      = 300000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_cmd_valid = 1'b0;
   logic [2:0]         req_func = 3'd0;
   logic [BYTE_W-1:0]  req_tx_byte = '0;
   logic               req_ack_bit = 1'b0;
   logic               req_sda_in = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_scl_level;
   logic               rsp_sda_level;
   logic               rsp_busy_res;
   logic               rsp_done_res;
   logic [BYTE_W-1:0]  rsp_rx_byte;
   logic               rsp_rx_ack;
   logic               rsp_nack_seen;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [TICKS_W-1:0] csr_phase_ticks = '0;

   int                 line_pending;
   int                 line_failures;
   int                 req_gap_max = 10;
   int                 rsp_gap_max = 10;
   logic               rsp_long_hold = 1'b0;
   int unsigned        cycle_count = 0;

   always #5 clock = ~clock;

   i2c_master_bit_sequencer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd_valid   (req_cmd_valid),
      .req_func        (req_func),
      .req_tx_byte     (req_tx_byte),
      .req_ack_bit     (req_ack_bit),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_rx_ack      (rsp_rx_ack),
      .rsp_nack_seen   (rsp_nack_seen),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_phase_ticks (csr_phase_ticks)
   );

   i2cms_line_checker line_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd_valid   (req_cmd_valid),
      .req_func        (req_func),
      .req_tx_byte     (req_tx_byte),
      .req_ack_bit     (req_ack_bit),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_level   (rsp_scl_level),
      .rsp_sda_level   (rsp_sda_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_rx_ack      (rsp_rx_ack),
      .rsp_nack_seen   (rsp_nack_seen),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_phase_ticks (csr_phase_ticks),
      .pending_count   (line_pending),
      .fail_count      (line_failures)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** i2c_master_bit_sequencer: FAILED **");
         $finish;
      end
   end

   // response side: random stall per word, one long hold when asked
   initial begin : rsp_side
      int   hold;
      logic long_taken;
      long_taken = 1'b0;
      forever begin
         if (rsp_long_hold && !long_taken) begin
            hold = LONG_HOLD_CYCLES;
            long_taken = 1'b1;
         end else begin
            hold = $urandom_range(0, rsp_gap_max);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_tick(input logic cv, input logic [2:0] fn, input logic [BYTE_W-1:0] tx,
                            input logic ak, input logic sd);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd_valid <= cv;
      req_func      <= fn;
      req_tx_byte   <= tx;
      req_ack_bit   <= ak;
      req_sda_in    <= sd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drain every pending word, then write the tick register
   task automatic set_phase_ticks(input logic [TICKS_W-1:0] ticks);
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_phase_ticks <= ticks;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // commands start often enough that most ticks run inside a sequence
   task automatic random_ticks(input int count);
      logic              cv;
      logic [2:0]        fn;
      logic [BYTE_W-1:0] tx;
      for (int i = 0; i < count; i++) begin
         cv = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 11) == 0)
            fn = $urandom_range(0, 1) ? FUNC_UNDEF_A : FUNC_UNDEF_B;
         else
            fn = 3'($urandom_range(int'(FUNC_START), int'(FUNC_RACK)));
         case ($urandom_range(0, 5))
            0:       tx = '0;
            1:       tx = '1;
            default: tx = BYTE_W'($urandom);
         endcase
         send_tick(cv, fn, tx, 1'($urandom), 1'($urandom));
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // unknown codes launch nothing, commands while busy are ignored
      send_tick(1'b1, FUNC_UNDEF_A, 8'hFF, 1'b1, 1'b1);
      send_tick(1'b1, FUNC_UNDEF_B, 8'h00, 1'b0, 1'b0);
      send_tick(1'b1, FUNC_START, 8'h00, 1'b0, 1'b0);
      repeat (3) send_tick(1'b1, FUNC_STOP, 8'hFF, 1'b1, 1'b1);
      send_tick(1'b1, FUNC_STOP, 8'h00, 1'b0, 1'b0);
      repeat (2) send_tick(1'b0, FUNC_STOP, 8'h00, 1'b0, 1'b0);
      send_tick(1'b1, FUNC_SACK, 8'h00, 1'b1, 1'b0);
      repeat (2) send_tick(1'b0, FUNC_SACK, 8'h00, 1'b0, 1'b0);
      send_tick(1'b1, FUNC_SACK, 8'hFF, 1'b0, 1'b1);
      repeat (2) send_tick(1'b0, FUNC_SACK, 8'h00, 1'b1, 1'b1);
      // a good ack after a nack leaves the sticky flag set
      repeat (3) send_tick(1'b1, FUNC_RACK, 8'h00, 1'b0, 1'b1);
      repeat (3) send_tick(1'b1, FUNC_RACK, 8'h00, 1'b0, 1'b0);

      // zero ticks behaves as one
      set_phase_ticks('0);
      random_ticks(12);
      // longest hold, then shortened in the middle of a write
      set_phase_ticks('1);
      send_tick(1'b1, FUNC_WRITE, 8'hFF, 1'b0, 1'b0);
      random_ticks(6);

      for (int p = 0; p < 8; p++) begin
         set_phase_ticks(TICKS_W'(1 + (p * 5) % 6));
         req_gap_max = (p == 4) ? 0 : 10;
         rsp_gap_max = req_gap_max;
         if (p == 2) begin
            req_gap_max = 1;
            rsp_long_hold = 1'b1;
         end
         random_ticks(205);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (line_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (line_failures == 0)
         $display("** i2c_master_bit_sequencer: PASSED **");
      else
         $display("** i2c_master_bit_sequencer: FAILED **");
      $finish;
   end

endmodule
